/* sv/fpexp_pkg.sv */
// Shared types, constants and elaboration-time tables for the fixed-point exponential.
package fpexp_pkg;

  localparam int unsigned XW     = 17;  // Q5.12 argument
  localparam int unsigned OUTW   = 56;  // Q24.32 result
  localparam int unsigned RW     = 12;  // |r| magnitude, up to 0.5 in Q12
  localparam int unsigned NW     = 5;   // |n|, 0..16
  localparam int unsigned PW     = 34;  // Horner partial sum, Q32
  localparam int unsigned ACCW   = 64;  // e^n in Q32 or e^-n in Q63
  localparam int unsigned NTERMS = 7;
  localparam int unsigned NPOW   = 17;

  localparam logic [63:0] Q32_ONE  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q63_ONE  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] E_Q32    = 64'h0000_0002_B7E1_5163;
  localparam logic [63:0] EINV_Q63 = 64'h2F16_AC6C_59DE_6F8D;

  typedef logic [PW-1:0]   coef_t;
  typedef logic [ACCW-1:0] pow_tbl_t [0:NPOW-1];

  // Taylor coefficients in Q32, highest order first (Horner order)
  localparam coef_t TAYLOR_COEF [0:NTERMS-1] = '{
    34'd5965232,     // 1/720
    34'd35791394,    // 1/120
    34'd178956971,   // 1/24
    34'd715827883,   // 1/6
    34'd2147483648,  // 1/2
    34'd4294967296,  // 1
    34'd4294967296   // 1
  };

  // Word travelling down the polynomial stages
  typedef struct packed {
    logic            neg;    // sign of x, selects Q63 scaling
    logic            r_neg;
    logic [RW-1:0]   r_mag;
    logic [ACCW-1:0] acc;    // e^|n| or e^-|n|
    logic [PW-1:0]   p;      // Horner partial sum
  } horner_t;

  // round(a*b / 2^s), low 64 bits; evaluated at elaboration only
  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned s);
    logic [127:0] prod;
    logic [127:0] half;
    half = 128'd1 << (s - 1);
    prod = ({64'd0, a} * {64'd0, b}) + half;
    prod = prod >> s;
    return prod[63:0];
  endfunction

  // e^n (Q32) or e^-n (Q63) for n in 0..16, built from repeated squaring
  function automatic pow_tbl_t build_pow(input logic neg);
    pow_tbl_t    tbl;
    logic [63:0] acc;
    logic [63:0] pw;
    int unsigned s;
    s = neg ? 32'd63 : 32'd32;
    for (int n = 0; n < NPOW; n++) begin
      acc = neg ? Q63_ONE : Q32_ONE;
      pw  = neg ? EINV_Q63 : E_Q32;
      for (int b = 0; b < NW; b++) begin
        if (((n >> b) & 1) != 0) begin
          acc = mul_round(acc, pw, s);
        end
        if (b < NW - 1) begin
          pw = mul_round(pw, pw, s);
        end
      end
      tbl[n] = acc;
    end
    return tbl;
  endfunction

  localparam pow_tbl_t POS_POW = build_pow(1'b0);
  localparam pow_tbl_t NEG_POW = build_pow(1'b1);

endpackage

/* sv/fpexp_reduce.sv */
// Range reduction: x -> nearest integer n and remainder r, plus e^n table lookup.
module fpexp_reduce
  import fpexp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [XW-1:0]  x_in_i,
  output logic           valid_o,
  output horner_t        data_o
);

  logic          neg;
  logic [XW-1:0] mag;
  logic [XW-1:0] mag_rnd;
  logic [NW-1:0] n_mag;
  logic [XW-1:0] n_sh;
  logic          ge;
  logic [XW-1:0] r_diff;
  horner_t       data_d;
  horner_t       data_q;
  logic          valid_q;

  always_comb begin
    neg     = x_in_i[XW-1];
    mag     = neg ? (~x_in_i + 17'd1) : x_in_i;
    // ties go toward zero; |x| + 2047 stays below 2^17
    mag_rnd = mag + 17'd2047;
    n_mag   = mag_rnd[XW-1:12];
    n_sh    = {n_mag[XW-13:0], 12'd0};
    ge      = (mag >= n_sh);
    r_diff  = ge ? (mag - n_sh) : (n_sh - mag);

    data_d.neg   = neg;
    data_d.r_neg = ge ? neg : ~neg;
    data_d.r_mag = r_diff[RW-1:0];
    data_d.acc   = neg ? NEG_POW[n_mag] : POS_POW[n_mag];
    data_d.p     = TAYLOR_COEF[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/fpexp_horner.sv */
// One Horner step of the e^r polynomial: p <- coef +/- round(|r| * p / 2^12).
module fpexp_horner
  import fpexp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  horner_t data_i,
  input  coef_t   coef_i,
  output logic    valid_o,
  output horner_t data_o
);

  localparam logic [46:0] HALF_LSB = 47'd2048;

  logic [46:0] prod;
  logic [34:0] t;
  logic [34:0] sum;
  horner_t     data_d;
  horner_t     data_q;
  logic        valid_q;

  always_comb begin
    prod   = (47'(data_i.r_mag) * 47'(data_i.p)) + HALF_LSB;
    t      = prod[46:12];
    sum    = data_i.r_neg ? (35'(coef_i) - t) : (35'(coef_i) + t);
    data_d   = data_i;
    data_d.p = sum[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/fpexp_scale.sv */
// Final e^r * e^n product in two 34x32 partial products, then round into Q32.
module fpexp_scale
  import fpexp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  horner_t         data_i,
  output logic            valid_o,
  output logic [OUTW-1:0] exp_out_o
);

  localparam logic [97:0] HALF_Q32 = 98'd1 << 31;
  localparam logic [97:0] HALF_Q63 = 98'd1 << 62;

  // stage A: low partial product
  logic          a_valid_q;
  logic [65:0]   a_lo_q;
  logic [PW-1:0] a_p_q;
  logic [31:0]   a_acc_hi_q;
  logic          a_neg_q;
  // stage B: high partial product
  logic          b_valid_q;
  logic [65:0]   b_lo_q;
  logic [65:0]   b_hi_q;
  logic          b_neg_q;
  // stage C: rounded result
  logic            c_valid_q;
  logic [OUTW-1:0] exp_q;

  logic [97:0]     sum;
  logic [97:0]     shifted;
  logic [OUTW-1:0] exp_d;

  always_comb begin
    sum     = {b_hi_q, 32'd0} + 98'(b_lo_q) + (b_neg_q ? HALF_Q63 : HALF_Q32);
    shifted = b_neg_q ? (sum >> 63) : (sum >> 32);
    exp_d   = shifted[OUTW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_lo_q     <= 66'(data_i.p) * 66'(data_i.acc[31:0]);
      a_p_q      <= data_i.p;
      a_acc_hi_q <= data_i.acc[63:32];
      a_neg_q    <= data_i.neg;
      b_lo_q     <= a_lo_q;
      b_hi_q     <= 66'(a_p_q) * 66'(a_acc_hi_q);
      b_neg_q    <= a_neg_q;
      exp_q      <= exp_d;
    end
  end

  assign valid_o   = c_valid_q;
  assign exp_out_o = exp_q;

endmodule

/* sv/fixed_point_exponential.sv */
// Fixed-point exponential: Q5.12 signed argument in, e^x as unsigned Q24.32 out.
//
// Channels: input word x_in_i with in_valid_i / in_ready_o, result word
// exp_out_o with out_valid_o / out_ready_i. A word moves when valid and
// ready are both high at a rising edge of clk_i.
// Every input word yields exactly one result word, in order.
// Pipeline: 10 register stages: one stage of range reduction and e^n
// lookup, six stages of Horner steps (one multiply each), two stages of
// partial products and one stage of final rounding.
// Throughput: one word per cycle unless stalled; at most one multiply per stage.
// Stall: the whole pipeline advances together while the output register is
// empty or being taken. When out_ready_i is low with a result waiting, the
// pipeline freezes and in_ready_o drops; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous): all valid bits clear, the block is empty
// and ready for input once reset is released.
module fixed_point_exponential
  import fpexp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [XW-1:0]   x_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [OUTW-1:0] exp_out_o
);

  logic    adv;
  logic    stg_valid [0:NTERMS-1];
  horner_t stg_data  [0:NTERMS-1];

  assign adv        = out_ready_i | ~out_valid_o;
  assign in_ready_o = adv;

  fpexp_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .x_in_i  (x_in_i),
    .valid_o (stg_valid[0]),
    .data_o  (stg_data[0])
  );

  for (genvar k = 1; k < NTERMS; k++) begin : g_horner
    fpexp_horner u_horner (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (stg_valid[k-1]),
      .data_i  (stg_data[k-1]),
      .coef_i  (TAYLOR_COEF[k]),
      .valid_o (stg_valid[k]),
      .data_o  (stg_data[k])
    );
  end

  fpexp_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (stg_valid[NTERMS-1]),
    .data_i    (stg_data[NTERMS-1]),
    .valid_o   (out_valid_o),
    .exp_out_o (exp_out_o)
  );

endmodule

/* bench/tb.sv */
// Self-checking testbench for the fixed-point exponential pipeline.
`timescale 1ns / 100ps

module tb
  import fpexp_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ARGS  = 600;
  localparam int TAIL_CYCLES = 30;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [XW-1:0]   x_in_i;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [OUTW-1:0] exp_out_o;

  typedef struct {
    logic [XW-1:0]   arg;
    logic [OUTW-1:0] value;
  } exp_entry_t;

  class exp_tracker;
    exp_entry_t pending_exp[$];
    int         mismatches;
    int         checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // round(a*b / 2^s) on the full 128-bit product
    function automatic logic [63:0] rounded_mul(logic [63:0] a, logic [63:0] b,
                                                int unsigned s);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      full = (full + (128'd1 << (s - 1))) >> s;
      return full[63:0];
    endfunction

    function automatic logic [63:0] taylor_coef(int k);
      case (k)
        0:       return 64'd5965232;
        1:       return 64'd35791394;
        2:       return 64'd178956971;
        3:       return 64'd715827883;
        4:       return 64'd2147483648;
        default: return 64'd4294967296;
      endcase
    endfunction

    function automatic logic [OUTW-1:0] predict_exp(logic [XW-1:0] x);
      logic        neg;
      logic        r_neg;
      logic [17:0] mag;
      logic [17:0] base;
      logic [4:0]  n_mag;
      logic [63:0] r_mag;
      logic [63:0] p;
      logic [63:0] t;
      logic [63:0] acc;
      logic [63:0] pw;
      logic [63:0] res;
      int unsigned s;
      neg   = x[XW-1];
      mag   = neg ? (18'h20000 - {1'b0, x}) : {1'b0, x};
      n_mag = 5'((mag + 18'd2047) >> 12);
      base  = {1'b0, n_mag, 12'd0};
      if (mag >= base) begin
        r_mag = 64'(mag - base);
        r_neg = neg;
      end else begin
        r_mag = 64'(base - mag);
        r_neg = !neg;
      end
      // Horner in Q32, sign of r applied per step
      p = taylor_coef(0);
      for (int k = 1; k < 7; k++) begin
        t = (r_mag * p + 64'd2048) >> 12;
        p = r_neg ? taylor_coef(k) - t : taylor_coef(k) + t;
      end
      // e^|n| in Q32, or e^-|n| in Q63
      s   = neg ? 63 : 32;
      acc = neg ? 64'h8000_0000_0000_0000 : 64'h0000_0001_0000_0000;
      pw  = neg ? 64'h2F16_AC6C_59DE_6F8D : 64'h0000_0002_B7E1_5163;
      for (int b = 0; b < 5; b++) begin
        if (n_mag[b]) begin
          acc = rounded_mul(acc, pw, s);
        end
        if (b < 4) begin
          pw = rounded_mul(pw, pw, s);
        end
      end
      res = rounded_mul(p, acc, s);
      return res[OUTW-1:0];
    endfunction

    function void add_arg(logic [XW-1:0] x);
      exp_entry_t e;
      e.arg   = x;
      e.value = predict_exp(x);
      pending_exp.push_back(e);
    endfunction

    function void check_exp(logic [OUTW-1:0] actual);
      exp_entry_t e;
      if (pending_exp.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, actual);
        mismatches++;
      end else begin
        e = pending_exp.pop_front();
        checked++;
        if (actual !== e.value) begin
          $display("%0t: exp_out mismatch for x=%h, expected %h, actual %h",
                   $time, e.arg, e.value, actual);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return pending_exp.size();
    endfunction
  endclass

  exp_tracker tracker;
  int         send_idle;
  int         recv_idle;
  int         quiet_cycles;
  int         args_sent;

  int corner_args [24] = '{
    -65536, 65535, 0, 1, -1, 2047, 2048, 2049, -2047, -2048, -2049, 4096,
    -4096, 6143, 6144, -6144, 63487, 63488, 63489, -63488, -63489, 32768,
    -32768, 21845
  };

  fixed_point_exponential DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_in_i      (x_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .exp_out_o   (exp_out_o)
  );

  always #2 clk_i = ~clk_i;

  // Monitor both channels, drive receiver backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (in_valid_i && in_ready_o) begin
        tracker.add_arg(x_in_i);
        args_sent = args_sent + 1;
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_exp(exp_out_o);
      end
    end
    out_ready_i <= (int'($urandom_range(99)) >= recv_idle);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_arg(int v);
    while (int'($urandom_range(99)) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_in_i     <= v[XW-1:0];
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  // Sender holds off until the pipeline has returned every result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly uniform words, the rest close to the rounding ties of x
  function automatic int pick_arg();
    int k;
    int v;
    if ($urandom_range(3) == 0) begin
      k = int'($urandom_range(32)) - 16;
      v = k * 4096 + (($urandom_range(1) == 1) ? 2048 : -2048) + int'($urandom_range(2)) - 1;
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
    end else begin
      v = int'($urandom_range(131071)) - 65536;
    end
    return v;
  endfunction

  initial begin
    tracker      = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    x_in_i       = '0;
    send_idle    = 37;
    recv_idle    = 77;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_args[i]) begin
      send_arg(corner_args[i]);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 37;
          recv_idle = 77;
        end
        1: begin
          send_idle = 77;
          recv_idle = 37;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ARGS; i++) begin
        send_arg(pick_arg());
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d arguments (%0d results checked): both range ends, rounding ties,",
             args_sent, tracker.checked);
    $display("n of zero, and three stall profiles with full drains between them.");
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
